### src/cspu_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and bit helpers for the can signal pack/unpack block
package cspu_pkg;

    localparam int PAYLOAD_BYTES_DEF = 64;
    localparam int BANK_AW_DEF       = 2;

    localparam int VALUE_W = 64;
    localparam int CFG_W   = 7;
    localparam int LEN_W   = 7;
    localparam int OFS_W   = 9;
    localparam int WIDX_W  = 3;
    localparam int SH_W    = 6;
    localparam int WIN_W   = 2 * VALUE_W;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_EXTRACT = 2'd2;
    localparam logic [1:0] ACT_INSERT  = 2'd3;

    localparam logic [1:0] TYPE_UNSIGNED = 2'd0;
    localparam logic [1:0] TYPE_SIGNED   = 2'd1;
    localparam logic [1:0] TYPE_FLOAT32  = 2'd2;
    localparam logic [1:0] TYPE_FLOAT64  = 2'd3;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_BAD_LENGTH  = 2'd1;
    localparam logic [1:0] STAT_PAST_FRAME  = 2'd2;
    localparam logic [1:0] STAT_PAST_LENGTH = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         byte_index;
        logic [7:0]         byte_value;
        logic [OFS_W-1:0]   bit_offset;
        logic [LEN_W-1:0]   bit_length;
        logic               intel_order;
        logic [1:0]         sig_kind;
        logic [VALUE_W-1:0] value_in;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic [1:0]         status;
    } t_out_word;

    // decoded operation, held for the whole read-modify-write pass
    typedef struct packed {
        logic               insert;
        logic [1:0]         status;
        logic [WIDX_W-1:0]  word_idx;
        logic [SH_W-1:0]    shift;
        logic [LEN_W-1:0]   len;
        logic               intel;
        logic               sgn;
        logic [VALUE_W-1:0] mask;
        logic [WIN_W-1:0]   win_mask;
        logic [WIN_W-1:0]   win_data;
    } t_op;

    // full 64-bit reversal
    function automatic logic [VALUE_W-1:0] rev64(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        for (int i = 0; i < VALUE_W; i++) begin
            r[i] = v[VALUE_W-1-i];
        end
        return r;
    endfunction

    // reverse the bits inside each byte, byte order kept
    function automatic logic [VALUE_W-1:0] rev_in_bytes(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        for (int b = 0; b < VALUE_W / 8; b++) begin
            for (int i = 0; i < 8; i++) begin
                r[8*b+i] = v[8*b+7-i];
            end
        end
        return r;
    endfunction

endpackage

### src/can_signal_pack_unpack.sv
`timescale 1ns / 1ps
// can_signal_pack_unpack: payload store with byte access and signal pack/unpack
//
// Input words arrive on i_in_valid/o_in_ready with a t_in_word payload; one
// t_out_word result per input word leaves on o_out_valid/i_out_ready.
// i_cfg_wr_en/i_cfg_wr_data write payload_length at any clock edge.
// One word is handled at a time: accept, bank read, window shift and merge,
// write-back with result load. The two word banks have a registered read,
// and a new word is taken only after the last one is written back. Payload
// words live in an even and an odd bank, so the two words a signal can span
// are read and written in the same cycle.
// Reset (synchronous, active low) clears the word valid bits, so the whole
// payload reads as zero at once; payload_length returns to 64. The banks
// themselves are not cleared.
// The result sits in an output register. A new word is accepted while a
// result waits; if the receiver stalls, the next result holds in write-back
// until the register frees, and input acceptance stops behind it.
module can_signal_pack_unpack #(
    parameter int PAYLOAD_BYTES = cspu_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  cspu_pkg::t_in_word          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cspu_pkg::t_out_word         o_out_data,
    input  logic                        i_cfg_wr_en,
    input  logic [cspu_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    localparam int WORDS   = (PAYLOAD_BYTES + 7) / 8;
    localparam int BANK_D  = (WORDS + 1) / 2;
    localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int VW      = cspu_pkg::VALUE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_DAT  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [cspu_pkg::CFG_W-1:0] r_payload_length;
    cspu_pkg::t_op              r_op;
    cspu_pkg::t_op              prep_op;
    logic [VW-1:0]              r_x, r_new_lo, r_new_hi;
    logic [VW-1:0]              x, new_lo, new_hi, value;
    logic                       r_out_valid, n_out_valid;
    cspu_pkg::t_out_word        r_out;

    logic [VW-1:0]              even_q, odd_q;
    logic [BANK_AW-1:0]         lo_addr, even_addr;
    logic [3:0]                 hi_word;
    logic                       hi_ok;
    logic                       in_fire, wb_fire, do_write;
    logic                       even_we, odd_we;
    logic [VW-1:0]              even_wd, odd_wd;

    cspu_prep #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_prep (
        .i_word           (i_in_data),
        .i_payload_length (r_payload_length),
        .o_op             (prep_op)
    );

    // word pair: lo at word_idx, hi at word_idx + 1 in the other bank
    assign hi_word   = 4'(r_op.word_idx) + 4'd1;
    assign hi_ok     = hi_word < 4'(WORDS);
    assign lo_addr   = BANK_AW'(r_op.word_idx >> 1);
    assign even_addr = r_op.word_idx[0] ? BANK_AW'(hi_word >> 1) : lo_addr;

    assign do_write = wb_fire && r_op.insert && (r_op.status == cspu_pkg::STAT_OK);
    assign even_we  = do_write && (!r_op.word_idx[0] || hi_ok);
    assign odd_we   = do_write && (r_op.word_idx[0] || hi_ok);
    assign even_wd  = r_op.word_idx[0] ? r_new_hi : r_new_lo;
    assign odd_wd   = r_op.word_idx[0] ? r_new_lo : r_new_hi;

    cspu_bank #(
        .ADDR_W (BANK_AW)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (even_addr),
        .o_rd_data (even_q),
        .i_wr_en   (even_we),
        .i_wr_addr (even_addr),
        .i_wr_data (even_wd)
    );

    cspu_bank #(
        .ADDR_W (BANK_AW)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (lo_addr),
        .o_rd_data (odd_q),
        .i_wr_en   (odd_we),
        .i_wr_addr (lo_addr),
        .i_wr_data (odd_wd)
    );

    cspu_field u_field (
        .i_op     (r_op),
        .i_even_q (even_q),
        .i_odd_q  (odd_q),
        .i_hi_ok  (hi_ok),
        .i_x_q    (r_x),
        .o_x      (x),
        .o_new_lo (new_lo),
        .o_new_hi (new_hi),
        .o_value  (value)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign wb_fire    = (r_state == S_WB) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_RD;
                end
            end
            S_RD:  n_state = S_DAT;
            S_DAT: n_state = S_WB;
            S_WB: begin
                if (wb_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (wb_fire) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_payload_length <= 7'd64;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_payload_length <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= prep_op;
        end
        if (r_state == S_DAT) begin
            r_x      <= x;
            r_new_lo <= new_lo;
            r_new_hi <= new_hi;
        end
        if (wb_fire) begin
            r_out.status    <= r_op.status;
            r_out.value_out <= (r_op.status == cspu_pkg::STAT_OK && !r_op.insert) ?
                               value : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/cspu_bank.sv
`timescale 1ns / 1ps
// one bank of 64-bit payload words with per-word valid bits, registered read
module cspu_bank #(
    parameter int ADDR_W = cspu_pkg::BANK_AW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output logic [cspu_pkg::VALUE_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [cspu_pkg::VALUE_W-1:0] i_wr_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [cspu_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_valid;
    logic [cspu_pkg::VALUE_W-1:0] r_rd_q;
    logic                         r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_q <= r_mem[i_rd_addr];
    end

    // a word never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

### src/cspu_prep.sv
`timescale 1ns / 1ps
// decodes an incoming word: checks, word position, masks and insert data
module cspu_prep #(
    parameter int PAYLOAD_BYTES = cspu_pkg::PAYLOAD_BYTES_DEF
) (
    input  cspu_pkg::t_in_word           i_word,
    input  logic [cspu_pkg::CFG_W-1:0]   i_payload_length,
    output cspu_pkg::t_op                o_op
);

    localparam int VW = cspu_pkg::VALUE_W;

    logic                       is_byte;
    logic [cspu_pkg::LEN_W-1:0] len;
    logic [cspu_pkg::OFS_W-1:0] ofs;
    logic                       intel;
    logic [VW-1:0]              value;
    logic [9:0]                 end_bit;
    logic [6:0]                 end_byte;
    logic [6:0]                 limit;
    logic [6:0]                 len_gap;
    logic [VW-1:0]              mask;
    logic [VW-1:0]              data;
    logic [1:0]                 status;

    always_comb begin
        is_byte = (i_word.action == cspu_pkg::ACT_WRITE) ||
                  (i_word.action == cspu_pkg::ACT_READ);

        // byte actions run as 8-bit intel signals at the byte's position
        if (is_byte) begin
            len   = 7'd8;
            ofs   = {i_word.byte_index, 3'b000};
            intel = 1'b1;
            value = {56'd0, i_word.byte_value};
        end else begin
            unique case (i_word.sig_kind)
                cspu_pkg::TYPE_FLOAT32: len = 7'd32;
                cspu_pkg::TYPE_FLOAT64: len = 7'd64;
                default:                len = i_word.bit_length;
            endcase
            ofs   = i_word.bit_offset;
            intel = i_word.intel_order;
            value = i_word.value_in;
        end

        end_bit  = 10'(ofs) + 10'(len);
        end_byte = 7'((end_bit + 10'd7) >> 3);
        limit    = (i_payload_length < 7'(PAYLOAD_BYTES)) ? i_payload_length
                                                          : 7'(PAYLOAD_BYTES);

        if (is_byte) begin
            status = ({1'b0, i_word.byte_index} >= 7'(PAYLOAD_BYTES)) ?
                     cspu_pkg::STAT_PAST_FRAME : cspu_pkg::STAT_OK;
        end else if (len == 7'd0 || len > 7'd64) begin
            status = cspu_pkg::STAT_BAD_LENGTH;
        end else if (end_bit > 10'(PAYLOAD_BYTES * 8)) begin
            status = cspu_pkg::STAT_PAST_FRAME;
        end else if (end_byte > limit) begin
            status = cspu_pkg::STAT_PAST_LENGTH;
        end else begin
            status = cspu_pkg::STAT_OK;
        end

        len_gap = 7'd64 - len;
        mask    = {VW{1'b1}} >> len_gap;
        // motorola: signal msb lands at the lowest stream bit
        data    = intel ? (value & mask) : (cspu_pkg::rev64(value) >> len_gap);

        o_op.insert   = (i_word.action == cspu_pkg::ACT_WRITE) ||
                        (i_word.action == cspu_pkg::ACT_INSERT);
        o_op.status   = status;
        o_op.word_idx = ofs[8:6];
        o_op.shift    = ofs[5:0];
        o_op.len      = len;
        o_op.intel    = intel;
        o_op.sgn      = !is_byte && (i_word.sig_kind == cspu_pkg::TYPE_SIGNED);
        o_op.mask     = mask;
        o_op.win_mask = {{VW{1'b0}}, mask} << ofs[5:0];
        o_op.win_data = {{VW{1'b0}}, data} << ofs[5:0];
    end

endmodule

### src/cspu_field.sv
`timescale 1ns / 1ps
// two-word window: signal extraction and bit merge for write-back
module cspu_field (
    input  cspu_pkg::t_op                 i_op,
    input  logic [cspu_pkg::VALUE_W-1:0]  i_even_q,
    input  logic [cspu_pkg::VALUE_W-1:0]  i_odd_q,
    input  logic                          i_hi_ok,
    input  logic [cspu_pkg::VALUE_W-1:0]  i_x_q,
    output logic [cspu_pkg::VALUE_W-1:0]  o_x,
    output logic [cspu_pkg::VALUE_W-1:0]  o_new_lo,
    output logic [cspu_pkg::VALUE_W-1:0]  o_new_hi,
    output logic [cspu_pkg::VALUE_W-1:0]  o_value
);

    localparam int VW = cspu_pkg::VALUE_W;

    logic [VW-1:0]               lo_raw;
    logic [VW-1:0]               hi_raw;
    logic [2*VW-1:0]             win;
    logic [2*VW-1:0]             win_sh;
    logic [2*VW-1:0]             win_new;
    logic [6:0]                  len_gap;
    logic [cspu_pkg::SH_W-1:0]   top_bit;
    logic [VW-1:0]               v;

    always_comb begin
        lo_raw = i_op.word_idx[0] ? i_odd_q : i_even_q;
        hi_raw = i_hi_ok ? (i_op.word_idx[0] ? i_even_q : i_odd_q) : '0;

        // motorola works in a domain where each byte is bit-reversed
        if (i_op.intel) begin
            win = {hi_raw, lo_raw};
        end else begin
            win = {cspu_pkg::rev_in_bytes(hi_raw), cspu_pkg::rev_in_bytes(lo_raw)};
        end

        win_sh  = win >> i_op.shift;
        o_x     = win_sh[VW-1:0];
        win_new = (win & ~i_op.win_mask) | i_op.win_data;

        if (i_op.intel) begin
            o_new_lo = win_new[VW-1:0];
            o_new_hi = win_new[2*VW-1:VW];
        end else begin
            o_new_lo = cspu_pkg::rev_in_bytes(win_new[VW-1:0]);
            o_new_hi = cspu_pkg::rev_in_bytes(win_new[2*VW-1:VW]);
        end

        // finish of extraction, from the registered window bits
        len_gap = 7'd64 - i_op.len;
        v       = i_op.intel ? (i_x_q & i_op.mask) : (cspu_pkg::rev64(i_x_q) >> len_gap);
        top_bit = 6'(i_op.len - 7'd1);
        if (i_op.sgn && v[top_bit]) begin
            v = v | ~i_op.mask;
        end
        o_value = v;
    end

endmodule
